### rtl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types, constants and arithmetic step functions of the arrow
// polygon tessellator.
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int unsigned ZERO_LENGTH_LIMIT = 1;
    localparam int unsigned SQRT_STAGES       = 16;
    localparam int unsigned DIV_STAGES        = 16;
    localparam int unsigned MIX_STAGES        = 8;

    localparam logic [30:0] REG_RESET = 31'd65536;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

    typedef enum logic [1:0] {
        REG_BODY_WIDTH  = 2'd0,
        REG_BARB_WIDTH  = 2'd1,
        REG_HEAD_LENGTH = 2'd2,
        REG_NONE        = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        V_BODY0 = 3'd0,
        V_BODY1 = 3'd1,
        V_BODY2 = 3'd2,
        V_BODY3 = 3'd3,
        V_HEAD0 = 3'd4,
        V_HEAD1 = 3'd5,
        V_HEAD2 = 3'd6,
        V_SPARE = 3'd7
    } vtx_t;

    // Geometry carried along the length pipeline.
    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] tail;
        logic [31:0] tip;
        logic        dx_neg;
        logic        dy_neg;
        logic [31:0] ax;
        logic [31:0] ay;
        logic        sh;
    } geo_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sq_t;

    typedef struct packed {
        geo_t        geo;
        sq_t         sq;
    } sq_stage_t;

    typedef struct packed {
        geo_t        geo;
        logic [32:0] len;
    } meas_t;

    typedef struct packed {
        meas_t       m;
        logic [33:0] rem_c;
        logic [33:0] rem_s;
        logic [33:0] rem_t;
        logic [31:0] q_c;
        logic [31:0] q_s;
        logic [15:0] q_t;
    } div_t;

    // One arrow, ready for vertex generation.
    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic        c_neg;
        logic [30:0] c_mag;
        logic        s_neg;
        logic [30:0] s_mag;
        logic [32:0] len;
        logic [32:0] a;
        logic [31:0] mid;
        logic [31:0] tail;
        logic [31:0] tip;
        logic        zero;
        logic        is_short;
    } arrow_t;

    // One restoring square root step (two radicand bits).
    function automatic sq_t sqrt_step(sq_t x);
        logic [35:0] t;
        logic [35:0] test;
        sq_t         y;
        t    = {x.rem, x.rad[63:62]};
        test = {2'b00, x.root, 2'b01};
        y.rad = {x.rad[61:0], 2'b00};
        if (t >= test)
        begin
            y.rem  = 34'(t - test);
            y.root = {x.root[30:0], 1'b1};
        end
        else
        begin
            y.rem  = t[33:0];
            y.root = {x.root[30:0], 1'b0};
        end
        return y;
    endfunction

    // One restoring division step: {quotient bit, new remainder}.
    function automatic logic [34:0] div_step(logic [33:0] rem, logic b, logic [32:0] d);
        logic [34:0] t;
        t = {rem, b};
        if (t >= {2'b00, d})
            return {1'b1, 34'(t - {2'b00, d})};
        else
            return {1'b0, t[33:0]};
    endfunction

    // Per-channel color mix; w_tail + w_tip = 65536.
    function automatic logic [31:0] mix_color(logic [31:0] ta, logic [31:0] tb,
                                              logic [16:0] w_tail, logic [16:0] w_tip);
        logic [31:0] res;
        logic [25:0] acc;
        for (int ch = 0; ch < 4; ch++)
        begin
            acc = 26'(ta[ch*8 +: 8]) * 26'(w_tail) + 26'(tb[ch*8 +: 8]) * 26'(w_tip)
                + 26'd32768;
            res[ch*8 +: 8] = acc[23:16];
        end
        return res;
    endfunction

endpackage

### rtl/arrow_polygon_tessellator.sv
// ----------------------------------------------------------------------------
// arrow_polygon_tessellator
// Turns one arrow (tail, tip, two colors) into the vertices of a body
// rectangle and a head triangle, in signed Q16.16 world coordinates.
// ----------------------------------------------------------------------------
// Usage: raise start with an arrow on the input ports; the transaction is
// taken at a rising edge where start is high and busy is low. The three
// shape registers are written through cfg_we, cfg_index and cfg_data at any
// edge with cfg_we high; write them only while no arrow is in flight.
// Each vertex appears for exactly one cycle with result_valid high. A full
// arrow gives seven vertices (body corners 0..3, then head corners 0..2), a
// short arrow three head vertices, and a near-zero arrow none. last_vertex
// marks the final vertex of an arrow.
// Pipeline: an accepted arrow passes through four stages for difference,
// squares and sum, sixteen square root stages, sixteen divider stages, a
// finishing stage, then the vertex sequencer and three datapath stages.
// Throughput: the front pipeline takes one arrow per cycle while busy is
// low; the vertex port then sets the rate at one vertex per cycle. busy is
// high while the front pipeline is held because the sequencer is still
// working. The receiver cannot stall. Reset empties every stage and loads
// 1.0 into each shape register.
// ----------------------------------------------------------------------------
module arrow_polygon_tessellator
    import apt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] end_x,
    input  logic [31:0] end_y,
    input  logic [31:0] tail_color,
    input  logic [31:0] tip_color,
    output logic        result_valid,
    output logic        part,
    output logic [1:0]  corner,
    output logic [31:0] vertex_x,
    output logic [31:0] vertex_y,
    output logic [31:0] vertex_color,
    output logic        last_vertex
);

    logic [30:0] body_width_reg, barb_width_reg, head_length_reg;
    logic        adv;
    logic        meas_valid, arrow_valid, emit_free;
    meas_t       meas;
    arrow_t      arrow;

    // Shape registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_width_reg  <= REG_RESET;
            barb_width_reg  <= REG_RESET;
            head_length_reg <= REG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BODY_WIDTH:  body_width_reg  <= cfg_data;
                REG_BARB_WIDTH:  barb_width_reg  <= cfg_data;
                REG_HEAD_LENGTH: head_length_reg <= cfg_data;
                REG_NONE:        ;
                default:         ;
            endcase
        end
    end

    // The whole front pipeline moves together; it holds only when its last
    // stage has an arrow that the sequencer cannot take yet.
    assign adv  = !arrow_valid || emit_free;
    assign busy = !adv;

    apt_measure u_measure (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (start && adv),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .tail_color (tail_color),
        .tip_color  (tip_color),
        .out_valid  (meas_valid),
        .out_meas   (meas)
    );

    apt_divide u_divide (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .head_length (head_length_reg),
        .in_valid    (meas_valid),
        .in_meas     (meas),
        .out_valid   (arrow_valid),
        .out_arrow   (arrow)
    );

    apt_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .body_width   (body_width_reg),
        .barb_width   (barb_width_reg),
        .in_valid     (arrow_valid),
        .in_arrow     (arrow),
        .free         (emit_free),
        .result_valid (result_valid),
        .part         (part),
        .corner       (corner),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_color (vertex_color),
        .last_vertex  (last_vertex)
    );

endmodule

### rtl/apt_measure.sv
// ----------------------------------------------------------------------------
// apt_measure
// Difference, squares and a pipelined square root giving the arrow length.
// ----------------------------------------------------------------------------
module apt_measure
    import apt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] end_x,
    input  logic [31:0] end_y,
    input  logic [31:0] tail_color,
    input  logic [31:0] tip_color,
    output logic        out_valid,
    output meas_t       out_meas
);

    logic        a_valid_reg;
    logic [31:0] a_sx_reg, a_sy_reg, a_ex_reg, a_ey_reg, a_tail_reg, a_tip_reg;

    logic        b_valid_reg;
    geo_t        b_geo_reg, b_geo_next;
    logic [30:0] b_x2_reg, b_y2_reg, b_x2_next, b_y2_next;

    logic        c_valid_reg;
    geo_t        c_geo_reg;
    logic [61:0] c_xx_reg, c_yy_reg;

    logic        d_valid_reg;
    geo_t        d_geo_reg;
    logic [63:0] d_sum_reg;

    logic        sq_valid_reg [SQRT_STAGES];
    sq_stage_t   sq_reg       [SQRT_STAGES];

    always_comb
    begin
        logic signed [32:0] dx, dy;
        logic        [32:0] mx, my;
        dx = $signed({a_ex_reg[31], a_ex_reg}) - $signed({a_sx_reg[31], a_sx_reg});
        dy = $signed({a_ey_reg[31], a_ey_reg}) - $signed({a_sy_reg[31], a_sy_reg});
        mx = dx[32] ? 33'(-dx) : 33'(dx);
        my = dy[32] ? 33'(-dy) : 33'(dy);
        b_geo_next.sx     = a_sx_reg;
        b_geo_next.sy     = a_sy_reg;
        b_geo_next.tail   = a_tail_reg;
        b_geo_next.tip    = a_tip_reg;
        b_geo_next.dx_neg = dx[32];
        b_geo_next.dy_neg = dy[32];
        b_geo_next.ax     = mx[31:0];
        b_geo_next.ay     = my[31:0];
        b_geo_next.sh     = mx[31] | my[31];
        b_x2_next = b_geo_next.sh ? mx[31:1] : mx[30:0];
        b_y2_next = b_geo_next.sh ? my[31:1] : my[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sx_reg   <= start_x;
            a_sy_reg   <= start_y;
            a_ex_reg   <= end_x;
            a_ey_reg   <= end_y;
            a_tail_reg <= tail_color;
            a_tip_reg  <= tip_color;
            b_geo_reg  <= b_geo_next;
            b_x2_reg   <= b_x2_next;
            b_y2_reg   <= b_y2_next;
            c_geo_reg  <= b_geo_reg;
            c_xx_reg   <= b_x2_reg * b_x2_reg;
            c_yy_reg   <= b_y2_reg * b_y2_reg;
            d_geo_reg  <= c_geo_reg;
            d_sum_reg  <= 64'(c_xx_reg) + 64'(c_yy_reg);
        end
    end

    // Two root bits per stage.
    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_sqrt
        sq_stage_t in_stage;
        logic      in_valid_s;
        sq_stage_t nxt;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                in_valid_s       = d_valid_reg;
                in_stage.geo     = d_geo_reg;
                in_stage.sq.rem  = '0;
                in_stage.sq.root = '0;
                in_stage.sq.rad  = d_sum_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                in_valid_s = sq_valid_reg[j-1];
                in_stage   = sq_reg[j-1];
            end
        end

        always_comb
        begin
            nxt.geo = in_stage.geo;
            nxt.sq  = sqrt_step(sqrt_step(in_stage.sq));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[j] <= 1'b0;
            else if (adv)
                sq_valid_reg[j] <= in_valid_s;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                sq_reg[j] <= nxt;
        end
    end

    always_comb
    begin
        sq_stage_t last;
        last          = sq_reg[SQRT_STAGES-1];
        out_valid     = sq_valid_reg[SQRT_STAGES-1];
        out_meas.geo  = last.geo;
        out_meas.len  = last.geo.sh ? {last.sq.root, 1'b0} : {1'b0, last.sq.root};
    end

endmodule

### rtl/apt_divide.sv
// ----------------------------------------------------------------------------
// apt_divide
// Pipelined dividers for the unit direction and the split-point weight,
// followed by a finishing stage that forms the arrow record.
// ----------------------------------------------------------------------------
module apt_divide
    import apt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [30:0] head_length,
    input  logic        in_valid,
    input  meas_t       in_meas,
    output logic        out_valid,
    output arrow_t      out_arrow
);

    logic   dv_valid_reg [DIV_STAGES];
    div_t   dv_reg       [DIV_STAGES];
    logic   f_valid_reg;
    arrow_t f_arrow_reg, f_arrow_next;

    // Two quotient bits per stage for the direction, two for the weight in
    // the first stages.
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        div_t in_d;
        logic in_valid_s;
        div_t nxt;
        logic b_hi, b_lo;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                in_valid_s = in_valid;
                in_d.m     = in_meas;
                in_d.rem_c = 34'(in_meas.geo.ax[31:2]);
                in_d.rem_s = 34'(in_meas.geo.ay[31:2]);
                in_d.rem_t = 34'(head_length);
                in_d.q_c   = '0;
                in_d.q_s   = '0;
                in_d.q_t   = '0;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                in_valid_s = dv_valid_reg[j-1];
                in_d       = dv_reg[j-1];
            end
        end

        always_comb
        begin
            logic [34:0] r1, r2;
            nxt = in_d;
            // Dividend is the magnitude shifted up by 30; only the first two
            // bits below the initial remainder come from it.
            b_hi = (j == 0) ? in_d.m.geo.ax[1] : 1'b0;
            b_lo = (j == 0) ? in_d.m.geo.ax[0] : 1'b0;
            r1 = div_step(in_d.rem_c, b_hi, in_d.m.len);
            r2 = div_step(r1[33:0], b_lo, in_d.m.len);
            nxt.rem_c = r2[33:0];
            nxt.q_c   = {in_d.q_c[29:0], r1[34], r2[34]};
            b_hi = (j == 0) ? in_d.m.geo.ay[1] : 1'b0;
            b_lo = (j == 0) ? in_d.m.geo.ay[0] : 1'b0;
            r1 = div_step(in_d.rem_s, b_hi, in_d.m.len);
            r2 = div_step(r1[33:0], b_lo, in_d.m.len);
            nxt.rem_s = r2[33:0];
            nxt.q_s   = {in_d.q_s[29:0], r1[34], r2[34]};
            if (j < MIX_STAGES)
            begin
                r1 = div_step(in_d.rem_t, 1'b0, in_d.m.len);
                r2 = div_step(r1[33:0], 1'b0, in_d.m.len);
                nxt.rem_t = r2[33:0];
                nxt.q_t   = {in_d.q_t[13:0], r1[34], r2[34]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (adv)
                dv_valid_reg[j] <= in_valid_s;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[j] <= nxt;
        end
    end

    always_comb
    begin
        div_t        d;
        logic [16:0] w_tip;
        d = dv_reg[DIV_STAGES-1];
        f_arrow_next.sx       = d.m.geo.sx;
        f_arrow_next.sy       = d.m.geo.sy;
        f_arrow_next.c_neg    = d.m.geo.dx_neg;
        f_arrow_next.s_neg    = d.m.geo.dy_neg;
        f_arrow_next.c_mag    = (d.q_c > 32'(Q30_ONE)) ? Q30_ONE : d.q_c[30:0];
        f_arrow_next.s_mag    = (d.q_s > 32'(Q30_ONE)) ? Q30_ONE : d.q_s[30:0];
        f_arrow_next.len      = d.m.len;
        f_arrow_next.tail     = d.m.geo.tail;
        f_arrow_next.tip      = d.m.geo.tip;
        f_arrow_next.zero     = (d.m.len == '0) || (d.m.len < 33'(ZERO_LENGTH_LIMIT));
        f_arrow_next.is_short = (d.m.len <= 33'(head_length));
        w_tip = 17'd65536 - 17'(d.q_t);
        if (f_arrow_next.is_short)
        begin
            f_arrow_next.a   = '0;
            f_arrow_next.mid = d.m.geo.tail;
        end
        else
        begin
            f_arrow_next.a   = d.m.len - 33'(head_length);
            f_arrow_next.mid = mix_color(d.m.geo.tail, d.m.geo.tip, 17'(d.q_t), w_tip);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (adv)
            f_valid_reg <= dv_valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            f_arrow_reg <= f_arrow_next;
    end

    assign out_valid = f_valid_reg;
    assign out_arrow = f_arrow_reg;

endmodule

### rtl/apt_emit.sv
// ----------------------------------------------------------------------------
// apt_emit
// Vertex sequencer and the rotate, round, offset and saturate datapath.
// ----------------------------------------------------------------------------
module apt_emit
    import apt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [30:0] body_width,
    input  logic [30:0] barb_width,
    input  logic        in_valid,
    input  arrow_t      in_arrow,
    output logic        free,
    output logic        result_valid,
    output logic        part,
    output logic [1:0]  corner,
    output logic [31:0] vertex_x,
    output logic [31:0] vertex_y,
    output logic [31:0] vertex_color,
    output logic        last_vertex
);

    typedef struct packed {
        logic        part;
        logic [1:0]  corner;
        logic [31:0] color;
        logic        last;
    } meta_t;

    arrow_t cur_reg;
    logic   cur_valid_reg;
    vtx_t   k_reg;
    logic   done;
    logic   issue;

    logic        px_neg, py_neg;
    logic [32:0] px_mag;
    logic [29:0] py_mag;
    meta_t       meta;

    logic        v1_valid_reg;
    meta_t       v1_meta_reg;
    logic [31:0] v1_sx_reg, v1_sy_reg;
    logic [63:0] v1_cx_reg, v1_sy_p_reg, v1_sx_p_reg, v1_cy_reg;
    logic        v1_ncx_reg, v1_nsy_reg, v1_nsx_reg, v1_ncy_reg;

    logic               v2_valid_reg;
    meta_t              v2_meta_reg;
    logic [31:0]        v2_sx_reg, v2_sy_reg;
    logic signed [34:0] v2_cx_reg, v2_sy_p_reg, v2_sx_p_reg, v2_cy_reg;

    logic        out_valid_reg;
    meta_t       out_meta_reg;
    logic [31:0] out_x_reg, out_y_reg, out_x_next, out_y_next;

    function automatic logic signed [34:0] round_q30(logic [63:0] p, logic neg);
        logic [63:0] r;
        r = p + 64'h2000_0000;
        return neg ? -$signed({1'b0, r[63:30]}) : $signed({1'b0, r[63:30]});
    endfunction

    function automatic logic [31:0] sat32(logic signed [36:0] v);
        if (v > 37'sh0_7FFF_FFFF)
            return 32'h7FFF_FFFF;
        else if (v < -37'sh0_8000_0000)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    assign issue = cur_valid_reg && !cur_reg.zero;
    assign done  = cur_valid_reg && (cur_reg.zero || (k_reg == V_HEAD2));
    assign free  = !cur_valid_reg || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            k_reg         <= V_BODY0;
        end
        else if (free && in_valid)
        begin
            cur_valid_reg <= 1'b1;
            k_reg         <= in_arrow.is_short ? V_HEAD0 : V_BODY0;
        end
        else if (done)
            cur_valid_reg <= 1'b0;
        else if (issue)
            k_reg <= vtx_t'(k_reg + 3'd1);
    end

    always_ff @(posedge clk)
    begin
        if (free && in_valid)
            cur_reg <= in_arrow;
    end

    // Local point and color of the current vertex.
    always_comb
    begin
        logic [29:0] hb, hh;
        hb = body_width[30:1];
        hh = barb_width[30:1];
        px_neg = 1'b0;
        py_neg = 1'b0;
        px_mag = '0;
        py_mag = '0;
        meta.color = cur_reg.tail;
        unique case (k_reg)
            V_BODY0:
            begin
                py_neg = 1'b1;
                py_mag = hb;
            end
            V_BODY1:
            begin
                px_mag = cur_reg.a;
                py_neg = 1'b1;
                py_mag = hb;
                meta.color = cur_reg.mid;
            end
            V_BODY2:
            begin
                px_mag = cur_reg.a;
                py_mag = hb;
                meta.color = cur_reg.mid;
            end
            V_BODY3:
            begin
                py_mag = hb;
            end
            V_HEAD0:
            begin
                px_mag = cur_reg.a;
                py_neg = 1'b1;
                py_mag = hh;
                meta.color = cur_reg.mid;
            end
            V_HEAD1:
            begin
                px_mag = cur_reg.len;
                meta.color = cur_reg.tip;
            end
            V_HEAD2:
            begin
                px_mag = cur_reg.a;
                py_mag = hh;
                meta.color = cur_reg.mid;
            end
            default:
            begin
                px_mag = '0;
            end
        endcase
        meta.part   = k_reg[2];
        meta.corner = k_reg[1:0];
        meta.last   = (k_reg == V_HEAD2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg  <= 1'b0;
            v2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_valid_reg  <= issue;
            v2_valid_reg  <= v1_valid_reg;
            out_valid_reg <= v2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_meta_reg <= meta;
        v1_sx_reg   <= cur_reg.sx;
        v1_sy_reg   <= cur_reg.sy;
        v1_cx_reg   <= 64'(cur_reg.c_mag) * 64'(px_mag);
        v1_sy_p_reg <= 64'(cur_reg.s_mag) * 64'(py_mag);
        v1_sx_p_reg <= 64'(cur_reg.s_mag) * 64'(px_mag);
        v1_cy_reg   <= 64'(cur_reg.c_mag) * 64'(py_mag);
        v1_ncx_reg  <= cur_reg.c_neg ^ px_neg;
        v1_nsy_reg  <= cur_reg.s_neg ^ py_neg;
        v1_nsx_reg  <= cur_reg.s_neg ^ px_neg;
        v1_ncy_reg  <= cur_reg.c_neg ^ py_neg;

        v2_meta_reg <= v1_meta_reg;
        v2_sx_reg   <= v1_sx_reg;
        v2_sy_reg   <= v1_sy_reg;
        v2_cx_reg   <= round_q30(v1_cx_reg, v1_ncx_reg);
        v2_sy_p_reg <= round_q30(v1_sy_p_reg, v1_nsy_reg);
        v2_sx_p_reg <= round_q30(v1_sx_p_reg, v1_nsx_reg);
        v2_cy_reg   <= round_q30(v1_cy_reg, v1_ncy_reg);

        out_meta_reg <= v2_meta_reg;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
    end

    always_comb
    begin
        logic signed [36:0] x, y;
        x = 37'(signed'(v2_sx_reg)) + 37'(v2_cx_reg) - 37'(v2_sy_p_reg);
        y = 37'(signed'(v2_sy_reg)) + 37'(v2_sx_p_reg) + 37'(v2_cy_reg);
        out_x_next = sat32(x);
        out_y_next = sat32(y);
    end

    assign result_valid = out_valid_reg;
    assign part         = out_meta_reg.part;
    assign corner       = out_meta_reg.corner;
    assign vertex_x     = out_x_reg;
    assign vertex_y     = out_y_reg;
    assign vertex_color = out_meta_reg.color;
    assign last_vertex  = out_meta_reg.last;

endmodule

### tb/sv/arrow_polygon_tessellator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrow_polygon_tessellator_tb
// Self-checking bench for the arrow tessellator. Arrows are sent through the
// start/busy command port, and each one is turned by a local predictor into
// the vertices it should produce. Every strobed vertex is checked field by
// field against the oldest expected vertex. The shape registers go through
// their reset values, the extremes and random settings between phases.
// ----------------------------------------------------------------------------
module arrow_polygon_tessellator_tb;
    import apt_pkg::*;

    typedef struct {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] tail;
        logic [31:0] tip;
    } arrow_in_t;

    typedef struct {
        logic        part;
        logic [1:0]  corner;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] color;
        logic        last;
    } vertex_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_BODY_WIDTH;
    logic [30:0] cfg_data = '0;
    logic [31:0] start_x = '0;
    logic [31:0] start_y = '0;
    logic [31:0] end_x = '0;
    logic [31:0] end_y = '0;
    logic [31:0] tail_color = '0;
    logic [31:0] tip_color = '0;
    logic        result_valid;
    logic        part;
    logic [1:0]  corner;
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [31:0] vertex_color;
    logic        last_vertex;

    // Shadow copies of the shape registers, as the predictor sees them.
    logic [30:0] body_width_q  = REG_RESET;
    logic [30:0] barb_width_q  = REG_RESET;
    logic [30:0] head_length_q = REG_RESET;

    vertex_t pending_vertices[$];
    int      error_count = 0;
    bit      no_gaps = 1'b0;

    arrow_polygon_tessellator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .tail_color   (tail_color),
        .tip_color    (tip_color),
        .result_valid (result_valid),
        .part         (part),
        .corner       (corner),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_color (vertex_color),
        .last_vertex  (last_vertex)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor arithmetic.
    // ------------------------------------------------------------------

    // Integer square root by the usual bit-pair method.
    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Q2.30 factor times a Q16.16 offset, rounded half away from zero.
    function automatic longint rotate_term(longint q, longint p);
        logic [63:0] qm;
        logic [63:0] pm;
        logic [63:0] m;
        qm = (q < 0) ? -q : q;
        pm = (p < 0) ? -p : p;
        m  = (qm * pm + 64'd536870912) >> 30;
        return ((q < 0) != (p < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] saturate(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic [31:0] blend_color(logic [31:0] a, logic [31:0] b,
                                                logic [63:0] t);
        logic [31:0] res;
        logic [63:0] c;
        for (int ch = 0; ch < 4; ch++)
        begin
            c = (64'(a[ch*8 +: 8]) * (65536 - t) + 64'(b[ch*8 +: 8]) * t + 32768) >> 16;
            res[ch*8 +: 8] = c[7:0];
        end
        return res;
    endfunction

    // Works out the vertices of one arrow and queues them in output order.
    task automatic predict_vertices(arrow_in_t a);
        longint      sx;
        longint      sy;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        longint      len;
        longint      split;
        longint      hb;
        longint      hh;
        longint      px[7];
        longint      py[7];
        logic [31:0] col[7];
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] length;
        logic [63:0] cm;
        logic [63:0] sm;
        logic [63:0] t;
        logic [31:0] mid;
        int          sh;
        int          first;
        vertex_t     v;
        sx = longint'(signed'(a.sx));
        sy = longint'(signed'(a.sy));
        dx = longint'(signed'(a.ex)) - sx;
        dy = longint'(signed'(a.ey)) - sy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        // Very long arrows are measured at half scale so the squares fit.
        sh = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) ? 1 : 0;
        length = int_sqrt((ax >> sh) * (ax >> sh) + (ay >> sh) * (ay >> sh)) << sh;
        if (length == 0 || length < ZERO_LENGTH_LIMIT)
            return;
        cm = (ax << 30) / length;
        sm = (ay << 30) / length;
        if (cm > 64'd1073741824)
            cm = 64'd1073741824;
        if (sm > 64'd1073741824)
            sm = 64'd1073741824;
        c   = (dx < 0) ? -longint'(cm) : longint'(cm);
        s   = (dy < 0) ? -longint'(sm) : longint'(sm);
        len = longint'(length);
        hb  = longint'(body_width_q >> 1);
        hh  = longint'(barb_width_q >> 1);
        if (length <= 64'(head_length_q))
        begin
            // Short arrow: the head triangle alone, from tail to tip.
            first = 4;
            px[4] = 0;   py[4] = -hh; col[4] = a.tail;
            px[5] = len; py[5] = 0;   col[5] = a.tip;
            px[6] = 0;   py[6] = hh;  col[6] = a.tail;
        end
        else
        begin
            first = 0;
            split = len - longint'(head_length_q);
            t     = 65536 - ((64'(head_length_q) << 16) / length);
            mid   = blend_color(a.tail, a.tip, t);
            px[0] = 0;     py[0] = -hb; col[0] = a.tail;
            px[1] = split; py[1] = -hb; col[1] = mid;
            px[2] = split; py[2] = hb;  col[2] = mid;
            px[3] = 0;     py[3] = hb;  col[3] = a.tail;
            px[4] = split; py[4] = -hh; col[4] = mid;
            px[5] = len;   py[5] = 0;   col[5] = a.tip;
            px[6] = split; py[6] = hh;  col[6] = mid;
        end
        for (int k = first; k < 7; k++)
        begin
            v.part   = (k >= 4);
            v.corner = (k >= 4) ? 2'(k - 4) : 2'(k);
            v.x      = saturate(sx + rotate_term(c, px[k]) - rotate_term(s, py[k]));
            v.y      = saturate(sy + rotate_term(s, px[k]) + rotate_term(c, py[k]));
            v.color  = col[k];
            v.last   = (k == 6);
            pending_vertices.push_back(v);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Each strobed vertex is taken at the rising edge that ends its cycle.
    always @(posedge clk)
    begin
        vertex_t exp_v;
        if (rst_n && result_valid)
        begin
            if (pending_vertices.size() == 0)
            begin
                report_mismatch("unexpected vertex x", vertex_x, 32'h0);
            end
            else
            begin
                exp_v = pending_vertices.pop_front();
                if (part !== exp_v.part)
                    report_mismatch("part", 32'(part), 32'(exp_v.part));
                if (corner !== exp_v.corner)
                    report_mismatch("corner", 32'(corner), 32'(exp_v.corner));
                if (vertex_x !== exp_v.x)
                    report_mismatch("vertex_x", vertex_x, exp_v.x);
                if (vertex_y !== exp_v.y)
                    report_mismatch("vertex_y", vertex_y, exp_v.y);
                if (vertex_color !== exp_v.color)
                    report_mismatch("vertex_color", vertex_color, exp_v.color);
                if (last_vertex !== exp_v.last)
                    report_mismatch("last_vertex", 32'(last_vertex), 32'(exp_v.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Presents one arrow and holds it until the transaction is accepted.
    task automatic send_arrow(arrow_in_t a);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start_x    = a.sx;
        start_y    = a.sy;
        end_x      = a.ex;
        end_y      = a.ey;
        tail_color = a.tail;
        tip_color  = a.tip;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_vertices(a);
    endtask

    // Drops start and waits until every arrow in flight has finished. An
    // arrow of near-zero length gives no vertex, so the queue alone cannot
    // tell that the pipeline is empty; the wait covers the full latency.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [30:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_BODY_WIDTH:  body_width_q  = val;
            REG_BARB_WIDTH:  barb_width_q  = val;
            REG_HEAD_LENGTH: head_length_q = val;
            default: ;
        endcase
    endtask

    task automatic set_shape(logic [30:0] bw, logic [30:0] hw, logic [30:0] hl);
        drain();
        write_reg(REG_BODY_WIDTH, bw);
        write_reg(REG_BARB_WIDTH, hw);
        write_reg(REG_HEAD_LENGTH, hl);
    endtask

    function automatic arrow_in_t make_arrow(longint sx, longint sy, longint ex,
                                             longint ey, logic [31:0] tail,
                                             logic [31:0] tip);
        arrow_in_t a;
        a.sx = sx[31:0];
        a.sy = sy[31:0];
        a.ex = ex[31:0];
        a.ey = ey[31:0];
        a.tail = tail;
        a.tip  = tip;
        return a;
    endfunction

    // Random arrow. Most are local strokes whose length is on the scale of
    // the head so that both short and full arrows come up; the rest are
    // anywhere in the plane, or degenerate.
    function automatic arrow_in_t random_arrow();
        arrow_in_t a;
        longint    sx;
        longint    sy;
        longint    span;
        int        mode;
        mode = $urandom_range(0, 9);
        a.tail = $urandom;
        a.tip  = $urandom;
        if (mode < 2)
        begin
            a.sx = $urandom;
            a.sy = $urandom;
            a.ex = $urandom;
            a.ey = $urandom;
        end
        else if (mode < 3)
        begin
            sx = longint'(signed'(32'($urandom)));
            sy = longint'(signed'(32'($urandom)));
            a  = make_arrow(sx, sy, sx + $urandom_range(0, 2) - 1,
                            sy + $urandom_range(0, 2) - 1, a.tail, a.tip);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: span = 64'd8;
                1: span = 64'd1 << 16;
                2: span = 64'd1 << 18;
                3: span = 64'(head_length_q) * 2 + 2;
                default: span = 64'd1 << 24;
            endcase
            if (span > 64'h7FFF_FFFF)
                span = 64'h7FFF_FFFF;
            sx = longint'(signed'(32'($urandom))) >>> $urandom_range(0, 14);
            sy = longint'(signed'(32'($urandom))) >>> $urandom_range(0, 14);
            a  = make_arrow(sx, sy,
                            sx + longint'($urandom_range(0, 32'(span * 2))) - span,
                            sy + longint'($urandom_range(0, 32'(span * 2))) - span,
                            a.tail, a.tip);
        end
        return a;
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_arrow(random_arrow());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset values: every case of the length against a head of 1.0.
    task automatic test_default_shape();
        longint one;
        longint lo;
        longint hi;
        one = 65536;
        lo  = -64'sd2147483648;
        hi  = 64'sd2147483647;
        // Zero length and the shortest arrow that still emits.
        send_arrow(make_arrow(100, 200, 100, 200, 32'hFFFF_FFFF, 32'h0));
        send_arrow(make_arrow(0, 0, 1, 0, 32'h1234_5678, 32'h9ABC_DEF0));
        // Exactly head length, then one unit over it.
        send_arrow(make_arrow(0, 0, 0, one, 32'h0, 32'hFFFF_FFFF));
        send_arrow(make_arrow(0, 0, one + 1, 0, 32'hFF00_FF00, 32'h00FF_00FF));
        // Full arrows in all four quadrants.
        send_arrow(make_arrow(0, 0, 5 * one, 3 * one, 32'h0, 32'hFFFF_FFFF));
        send_arrow(make_arrow(0, 0, -7 * one, 2 * one, 32'hFFFF_FFFF, 32'h0));
        send_arrow(make_arrow(one, one, -3 * one, -9 * one, 32'h8080_8080, 32'h7F7F_7F7F));
        send_arrow(make_arrow(-one, 0, 4 * one, -4 * one, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        // Field extremes: the longest arrows, scaled during measurement.
        send_arrow(make_arrow(lo, lo, hi, hi, 32'h0, 32'hFFFF_FFFF));
        send_arrow(make_arrow(hi, lo, lo, hi, 32'hFFFF_FFFF, 32'h0));
        send_arrow(make_arrow(lo, 0, hi, 0, 32'h0102_0304, 32'hFDFE_FF00));
        // Vertices pushed past the coordinate range must saturate.
        send_arrow(make_arrow(hi, hi, hi - 2 * one, hi, 32'h0, 32'h0));
        send_arrow(make_arrow(lo, lo, lo, lo + 3 * one, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // Register extremes, the ignored index and zero widths.
    task automatic test_extreme_shapes();
        longint one;
        one = 65536;
        set_shape(31'h0, 31'h0, 31'h0);
        // A write to the unused index must change nothing.
        write_reg(REG_NONE, 31'h7FFF_FFFF);
        send_arrow(make_arrow(0, 0, 3 * one, one, 32'h1122_3344, 32'h5566_7788));
        send_arrow(make_arrow(0, 0, 1, 0, 32'hFFFF_FFFF, 32'h0));
        send_arrow(make_arrow(7, 7, 7, 7, 32'h0, 32'h0));
        set_shape(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_arrow(make_arrow(0, 0, 2 * one, 2 * one, 32'h0, 32'hFFFF_FFFF));
        send_arrow(make_arrow(-64'sd2147483648, 0, 64'sd2147483647, 0, 32'h0, 32'hFFFF_FFFF));
        send_arrow(make_arrow(-64'sd2147483648, -64'sd2147483648,
                              64'sd2147483647, 64'sd2147483647, 32'hFF, 32'hFF00_0000));
        set_shape(31'h7FFF_FFFF, 31'h1, 31'h1);
        send_arrow(make_arrow(0, 0, 10 * one, -one, 32'h0, 32'hFFFF_FFFF));
        send_arrow(make_arrow(0, 0, 2, 0, 32'h00FF_00FF, 32'hFF00_FF00));
    endtask

    // Random arrows under several shape settings; one phase runs back to
    // back with no gaps at all.
    task automatic test_random_shapes();
        send_random(50);
        set_shape(REG_RESET, REG_RESET, REG_RESET);
        no_gaps = 1'b1;
        send_random(40);
        no_gaps = 1'b0;
        for (int p = 0; p < 4; p++)
        begin
            set_shape(31'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 20)),
                      31'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 20)),
                      31'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(8, 22)));
            send_random(40);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_default_shape();
        test_extreme_shapes();
        test_random_shapes();
        drain();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
